// ----- rtl/tsi_pkg.sv -----
// tsi_pkg: shared types and constants of the two-axis step interpolator
// no dependencies

package tsi_pkg;

    localparam int POS_BITS_DEF = 13;
    localparam int CNT_W        = 14;
    localparam int TGT_W        = 14;
    localparam int DLY_W        = 16;
    localparam int LIM_W        = 12;
    localparam int OP_W         = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = LIM_W;

    localparam logic [LIM_W-1:0] LIMIT_X_RST = 12'd1500;
    localparam logic [LIM_W-1:0] LIMIT_Y_RST = 12'd4095;

    localparam logic [OP_W-1:0] OP_ADVANCE  = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE_REL = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE_ABS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y = 1'd1;

    typedef struct packed {
        logic [CNT_W-1:0] count_x;
        logic [CNT_W-1:0] count_y;
        logic [CNT_W-1:0] major;
        logic             dir_x;
        logic             dir_y;
    } move_t;

    typedef struct packed {
        logic step_x;
        logic step_y;
        logic dir_x;
        logic dir_y;
        logic busy;
        logic last;
        logic rejected;
    } res_flags_t;

endpackage

// ----- rtl/tsi_cmd_if.sv -----
// tsi_cmd_if: command channel, valid/ready handshake with the input item
// depends on tsi_pkg

interface tsi_cmd_if import tsi_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [TGT_W-1:0] target_x;
    logic signed [TGT_W-1:0] target_y;
    logic [DLY_W-1:0]        step_delay;

    modport source (output valid, output opcode, output target_x, output target_y,
                    output step_delay, input ready);
    modport sink   (input valid, input opcode, input target_x, input target_y,
                    input step_delay, output ready);
endinterface

// ----- rtl/tsi_rsp_if.sv -----
// tsi_rsp_if: result channel, valid/ready handshake with the result item
// depends on tsi_pkg

interface tsi_rsp_if import tsi_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic                       step_x;
    logic                       step_y;
    logic                       dir_x;
    logic                       dir_y;
    logic signed [POS_BITS-1:0] pos_x_out;
    logic signed [POS_BITS-1:0] pos_y_out;
    logic [DLY_W-1:0]           delay_out;
    logic                       busy_res;
    logic                       last;
    logic                       rejected;

    modport source (output valid, output step_x, output step_y, output dir_x,
                    output dir_y, output pos_x_out, output pos_y_out, output delay_out,
                    output busy_res, output last, output rejected, input ready);
    modport sink   (input valid, input step_x, input step_y, input dir_x,
                    input dir_y, input pos_x_out, input pos_y_out, input delay_out,
                    input busy_res, input last, input rejected, output ready);
endinterface

// ----- rtl/tsi_move_calc.sv -----
// tsi_move_calc: clamps the move target per axis and derives step counts
// depends on tsi_pkg

module tsi_move_calc import tsi_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                       absolute,
    input  logic signed [TGT_W-1:0]    target_x,
    input  logic signed [TGT_W-1:0]    target_y,
    input  logic signed [POS_BITS-1:0] pos_x,
    input  logic signed [POS_BITS-1:0] pos_y,
    input  logic [LIM_W-1:0]           limit_x,
    input  logic [LIM_W-1:0]           limit_y,
    output move_t                      move
);

    localparam int SW = ((POS_BITS > TGT_W) ? POS_BITS : TGT_W) + 2;
    localparam logic signed [SW-1:0] CAP = SW'((64'd1 << (POS_BITS - 1)) - 64'd1);

    function automatic logic signed [SW-1:0] clamp_final(
        input logic signed [SW-1:0] f,
        input logic [LIM_W-1:0]     limit
    );
        logic signed [SW-1:0] lim;
        lim = signed'({{(SW-LIM_W){1'b0}}, limit});
        if (lim > CAP)
        begin
            lim = CAP;
        end
        if (f > lim)
        begin
            return lim;
        end
        if (f < -lim)
        begin
            return -lim;
        end
        return f;
    endfunction

    logic signed [SW-1:0] px;
    logic signed [SW-1:0] py;
    logic signed [SW-1:0] tx;
    logic signed [SW-1:0] ty;
    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] dy;
    logic signed [SW-1:0] ax;
    logic signed [SW-1:0] ay;
    logic [CNT_W-1:0]     cx;
    logic [CNT_W-1:0]     cy;

    always_comb
    begin
        px = SW'(pos_x);
        py = SW'(pos_y);
        tx = SW'(target_x);
        ty = SW'(target_y);
        dx = clamp_final(absolute ? tx : px + tx, limit_x) - px;
        dy = clamp_final(absolute ? ty : py + ty, limit_y) - py;
        ax = dx[SW-1] ? -dx : dx;
        ay = dy[SW-1] ? -dy : dy;
        cx = ax[CNT_W-1:0];
        cy = ay[CNT_W-1:0];
        move.count_x = cx;
        move.count_y = cy;
        move.major   = (cx > cy) ? cx : cy;
        move.dir_x   = (dx <= 0);
        move.dir_y   = (dy <= 0);
    end

endmodule

// ----- rtl/tsi_core.sv -----
// tsi_core: move state, one bresenham iteration per advance item
// depends on tsi_pkg and tsi_move_calc

module tsi_core import tsi_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       proc,
    input  logic [OP_W-1:0]            opcode,
    input  logic signed [TGT_W-1:0]    target_x,
    input  logic signed [TGT_W-1:0]    target_y,
    input  logic [DLY_W-1:0]           step_delay,
    input  logic [LIM_W-1:0]           limit_x,
    input  logic [LIM_W-1:0]           limit_y,
    output logic signed [POS_BITS-1:0] pos_x,
    output logic signed [POS_BITS-1:0] pos_y,
    output logic [DLY_W-1:0]           delay,
    output res_flags_t                 flags
);

    logic signed [POS_BITS-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_BITS-1:0] pos_y_reg, pos_y_next;
    logic [CNT_W-1:0]           acc_x_reg, acc_x_next;
    logic [CNT_W-1:0]           acc_y_reg, acc_y_next;
    logic [CNT_W-1:0]           count_x_reg, count_x_next;
    logic [CNT_W-1:0]           count_y_reg, count_y_next;
    logic [CNT_W-1:0]           major_reg, major_next;
    logic [CNT_W-1:0]           iter_left_reg, iter_left_next;
    logic [1:0]                 dir_reg, dir_next;
    logic [DLY_W-1:0]           delay_reg, delay_next;
    logic [CNT_W-1:0]           sum_x;
    logic [CNT_W-1:0]           sum_y;
    logic                       busy;
    move_t                      move;

    tsi_move_calc #(
        .POS_BITS (POS_BITS)
    ) u_move_calc (
        .absolute (opcode == OP_MOVE_ABS),
        .target_x (target_x),
        .target_y (target_y),
        .pos_x    (pos_x_reg),
        .pos_y    (pos_y_reg),
        .limit_x  (limit_x),
        .limit_y  (limit_y),
        .move     (move)
    );

    assign busy  = (iter_left_reg != '0);
    assign sum_x = acc_x_reg + count_x_reg;
    assign sum_y = acc_y_reg + count_y_reg;

    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        count_x_next   = count_x_reg;
        count_y_next   = count_y_reg;
        major_next     = major_reg;
        iter_left_next = iter_left_reg;
        dir_next       = dir_reg;
        delay_next     = delay_reg;
        flags          = '0;
        case (opcode)
            OP_MOVE_REL, OP_MOVE_ABS:
            begin
                if (busy)
                begin
                    flags.rejected = 1'b1;
                end
                else
                begin
                    count_x_next   = move.count_x;
                    count_y_next   = move.count_y;
                    major_next     = move.major;
                    iter_left_next = move.major;
                    acc_x_next     = '0;
                    acc_y_next     = '0;
                    dir_next       = {move.dir_y, move.dir_x};
                    delay_next     = step_delay;
                    flags.last     = (move.major == '0);
                end
            end
            OP_ADVANCE:
            begin
                if (busy)
                begin
                    acc_x_next = sum_x;
                    acc_y_next = sum_y;
                    if (sum_x >= major_reg)
                    begin
                        acc_x_next   = sum_x - major_reg;
                        flags.step_x = 1'b1;
                        pos_x_next   = dir_reg[0] ? pos_x_reg - POS_BITS'(1)
                                                  : pos_x_reg + POS_BITS'(1);
                    end
                    if (sum_y >= major_reg)
                    begin
                        acc_y_next   = sum_y - major_reg;
                        flags.step_y = 1'b1;
                        pos_y_next   = dir_reg[1] ? pos_y_reg - POS_BITS'(1)
                                                  : pos_y_reg + POS_BITS'(1);
                    end
                    iter_left_next = iter_left_reg - CNT_W'(1);
                    flags.last     = (iter_left_next == '0);
                end
            end
            default:
            begin
            end
        endcase
        flags.dir_x = dir_next[0];
        flags.dir_y = dir_next[1];
        flags.busy  = (iter_left_next != '0);
        pos_x       = pos_x_next;
        pos_y       = pos_y_next;
        delay       = delay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            count_x_reg   <= '0;
            count_y_reg   <= '0;
            major_reg     <= '0;
            iter_left_reg <= '0;
            dir_reg       <= '0;
            delay_reg     <= '0;
        end
        else if (proc)
        begin
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            count_x_reg   <= count_x_next;
            count_y_reg   <= count_y_next;
            major_reg     <= major_next;
            iter_left_reg <= iter_left_next;
            dir_reg       <= dir_next;
            delay_reg     <= delay_next;
        end
    end

    a_acc_x_below_major: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (acc_x_reg < major_reg && acc_y_reg < major_reg))
        else $error("accumulator not below major count during a move");

    a_counts_within_major: assert property (@(posedge clk) disable iff (!rst_n)
        (count_x_reg <= major_reg && count_y_reg <= major_reg))
        else $error("axis count exceeds major count");

    a_step_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
        (flags.step_x || flags.step_y || flags.rejected) |-> busy)
        else $error("step or reject without an active move");

    a_iter_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && opcode == OP_ADVANCE && busy)
        |=> iter_left_reg == $past(iter_left_reg) - CNT_W'(1))
        else $error("iteration count did not drop by one");

    a_reject_holds_move: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && flags.rejected)
        |=> (major_reg == $past(major_reg) && iter_left_reg == $past(iter_left_reg)))
        else $error("rejected move changed the active move");

endmodule

// ----- rtl/two_axis_step_interpolator_top.sv -----
// two_axis_step_interpolator_top: input register, move core, result register, limits
// depends on tsi_pkg, tsi_cmd_if, tsi_rsp_if and tsi_core
//
// usage
// - cmd channel carries one item: opcode (advance, move relative, move absolute),
//   target_x, target_y and step_delay; an item is taken when valid and ready are high
// - a move loads only while no iterations remain; otherwise it is reported as rejected
// - each advance item runs one bresenham iteration on both axes and yields the step
//   pulses, directions, positions, busy and last flags
// - rsp channel returns exactly one result item per command item, in order
// - cfg_we / cfg_index / cfg_data write limit_x (index 0) or limit_y (index 1);
//   write them only while the block is idle
// - a taken item passes the input register and the core and is shown from the result register
// - throughput: one item per cycle while rsp does not stall; the per-axis accumulate,
//   compare and subtract in the core is combinational
// - reset clears positions and move state, limit_x returns to 1500, limit_y to 4095
// - when rsp stalls, the result register holds and one more item waits in the
//   input register; cmd ready drops only when both are full

module two_axis_step_interpolator_top import tsi_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tsi_cmd_if.sink               cmd,
    tsi_rsp_if.source             rsp
);

    logic                       in_valid_reg, in_valid_next;
    logic [OP_W-1:0]            op_reg;
    logic signed [TGT_W-1:0]    tx_reg;
    logic signed [TGT_W-1:0]    ty_reg;
    logic [DLY_W-1:0]           dly_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [POS_BITS-1:0] pos_x_reg;
    logic signed [POS_BITS-1:0] pos_y_reg;
    logic [DLY_W-1:0]           delay_reg;
    res_flags_t                 flags_reg;
    logic [LIM_W-1:0]           limit_x_reg;
    logic [LIM_W-1:0]           limit_y_reg;
    logic                       proc;
    logic                       take;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic [DLY_W-1:0]           delay;
    res_flags_t                 flags;

    assign proc      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || proc;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    tsi_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc       (proc),
        .opcode     (op_reg),
        .target_x   (tx_reg),
        .target_y   (ty_reg),
        .step_delay (dly_reg),
        .limit_x    (limit_x_reg),
        .limit_y    (limit_y_reg),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .delay      (delay),
        .flags      (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_x_reg   <= LIMIT_X_RST;
            limit_y_reg   <= LIMIT_Y_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LIMIT_X: limit_x_reg <= cfg_data[LIM_W-1:0];
                    REG_LIMIT_Y: limit_y_reg <= cfg_data[LIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg  <= cmd.opcode;
            tx_reg  <= cmd.target_x;
            ty_reg  <= cmd.target_y;
            dly_reg <= cmd.step_delay;
        end
        if (proc)
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            delay_reg <= delay;
            flags_reg <= flags;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.step_x    = flags_reg.step_x;
    assign rsp.step_y    = flags_reg.step_y;
    assign rsp.dir_x     = flags_reg.dir_x;
    assign rsp.dir_y     = flags_reg.dir_y;
    assign rsp.pos_x_out = pos_x_reg;
    assign rsp.pos_y_out = pos_y_reg;
    assign rsp.delay_out = delay_reg;
    assign rsp.busy_res  = flags_reg.busy;
    assign rsp.last      = flags_reg.last;
    assign rsp.rejected  = flags_reg.rejected;

endmodule
